>>> design/contiguous_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous block allocator
// Implication, next-cycle and never-true checks, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBA_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");
`define CBA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");
`define CBA_ASSERT_NEVER(lbl, clk, rst_n, a) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("forbidden condition seen");
`else
`define CBA_ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define CBA_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`define CBA_ASSERT_NEVER(lbl, clk, rst_n, a)
`endif
`endif

>>> design/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared constants and codes of the contiguous block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package cba_pkg;
    localparam int MEM_UNITS_DEF = 256;

    localparam int OWNER_W  = 8;
    localparam int UNITS_W  = 9;
    localparam int STATUS_W = 3;
    localparam int VISIT_W  = 9;
    localparam int FRAG_W   = 8;
    localparam int CNT_W    = 32;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // placement rule
    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    // result status
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
endpackage
`default_nettype wire

>>> design/cba_if.sv
// ----------------------------------------------------------------------------
// cba channels
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface cba_req_if;
    import cba_pkg::*;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [OWNER_W-1:0]  owner_id;
    logic [UNITS_W-1:0]  unit_count;
    modport source (output valid, req_type, owner_id, unit_count, input ready);
    modport sink   (input valid, req_type, owner_id, unit_count, output ready);
endinterface

interface cba_rsp_if;
    import cba_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VISIT_W-1:0]  nodes_visited;
    logic [FRAG_W-1:0]   small_fragments;
    logic [CNT_W-1:0]    granted_total;
    logic [CNT_W-1:0]    denied_total;
    logic [CNT_W-1:0]    visited_total;
    modport source (output valid, status, nodes_visited, small_fragments,
                    granted_total, denied_total, visited_total, input ready);
    modport sink   (input valid, status, nodes_visited, small_fragments,
                    granted_total, denied_total, visited_total, output ready);
endinterface

interface cba_cfg_if;
    logic valid;
    logic ready;
    logic fit_mode;
    modport source (output valid, fit_mode, input ready);
    modport sink   (input valid, fit_mode, output ready);
endinterface
`default_nettype wire

>>> design/contiguous_block_allocator.sv
// Contiguous block allocator: one request at a time, walked through a block table
// memory by a sequencer with a single read port. A request runs a search over the
// blocks of the table, moves entries up when a split opens a slot, moves entries
// down when a merge closes one (up to two merges per free), and then recounts the
// small fragments over the blocks that are left; the table's single read port,
// one entry at a time, sets the pace of every step.
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// First-fit / best-fit allocator over an address-ordered block table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "contiguous_block_allocator_assert.svh"
module contiguous_block_allocator #(
    parameter int MEM_UNITS = cba_pkg::MEM_UNITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cba_cfg_if.sink    cfg,
    cba_req_if.sink    req,
    cba_rsp_if.source  rsp
);
    import cba_pkg::*;

    localparam int IW = $clog2(MEM_UNITS);
    localparam int CW = $clog2(MEM_UNITS + 1);
    localparam int SW = CW;
    localparam int EW = 1 + OWNER_W + SW;
    localparam int UW = (SW > UNITS_W) ? SW : UNITS_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SC_RD  = 5'd1;
    localparam logic [4:0] S_SC_EV  = 5'd2;
    localparam logic [4:0] S_G_DEC  = 5'd3;
    localparam logic [4:0] S_SH_RD  = 5'd4;
    localparam logic [4:0] S_SH_WR  = 5'd5;
    localparam logic [4:0] S_G_WR   = 5'd6;
    localparam logic [4:0] S_G_WR2  = 5'd7;
    localparam logic [4:0] S_NX_RD  = 5'd8;
    localparam logic [4:0] S_NX_EV  = 5'd9;
    localparam logic [4:0] S_F_WK   = 5'd10;
    localparam logic [4:0] S_PV_RD  = 5'd11;
    localparam logic [4:0] S_PV_EV  = 5'd12;
    localparam logic [4:0] S_RM_CK  = 5'd13;
    localparam logic [4:0] S_RM_RD  = 5'd14;
    localparam logic [4:0] S_RM_WR  = 5'd15;
    localparam logic [4:0] S_FR_RD  = 5'd16;
    localparam logic [4:0] S_FR_EV  = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0]          state_reg, state_next;
    logic                mode_reg, mode_next;
    logic                cur_mode_reg, cur_mode_next;
    logic                rtype_reg, rtype_next;
    logic [OWNER_W-1:0]  own_reg, own_next;
    logic [UNITS_W-1:0]  units_reg, units_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       pick_reg, pick_next;
    logic [CW-1:0]       walked_reg, walked_next;
    logic [SW-1:0]       best_reg, best_next;
    logic                found_reg, found_next;
    logic                rm_ret_reg, rm_ret_next;
    logic [CW-1:0]       frag_reg, frag_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [CW-1:0]       vis_reg, vis_next;
    logic [CNT_W-1:0]    gcnt_reg, gcnt_next;
    logic [CNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]    vsum_reg, vsum_next;

    logic                ov_reg, ov_next;
    logic [STATUS_W-1:0] o_st_reg, o_st_next;
    logic [VISIT_W-1:0]  o_vis_reg, o_vis_next;
    logic [FRAG_W-1:0]   o_frag_reg, o_frag_next;
    logic [CNT_W-1:0]    o_g_reg, o_g_next;
    logic [CNT_W-1:0]    o_d_reg, o_d_next;
    logic [CNT_W-1:0]    o_v_reg, o_v_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    logic               rd_free;
    logic [OWNER_W-1:0] rd_owner;
    logic [SW-1:0]      rd_size;
    logic               fits;
    logic               last;
    logic               load_out;
    logic [CW-1:0]      k_inc;
    logic [CW-1:0]      j_dec;

    cba_table #(.MEM_UNITS(MEM_UNITS), .IW(IW), .EW(EW)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_free  = rd_data[EW-1];
    assign rd_owner = rd_data[SW +: OWNER_W];
    assign rd_size  = rd_data[SW-1:0];
    assign fits     = rd_free && (UW'(rd_size) >= UW'(units_reg));
    assign k_inc    = k_reg + 1'b1;
    assign j_dec    = j_reg - 1'b1;
    assign last     = (k_inc == count_reg);
    assign load_out = (state_reg == S_DONE) && (!ov_reg || rsp.ready);

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cur_mode_next = cur_mode_reg;
        rtype_next    = rtype_reg;
        own_next      = own_reg;
        units_next    = units_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        pick_next     = pick_reg;
        walked_next   = walked_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        rm_ret_next   = rm_ret_reg;
        frag_next     = frag_reg;
        st_next       = st_reg;
        vis_next      = vis_reg;
        gcnt_next     = gcnt_reg;
        dcnt_next     = dcnt_reg;
        vsum_next     = vsum_reg;
        wr_en         = 1'b0;
        wr_addr       = pick_reg[IW-1:0];
        wr_data       = '0;
        rd_addr       = k_reg[IW-1:0];

        if (cfg.valid)
        begin
            mode_next = cfg.fit_mode;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rtype_next    = req.req_type;
                    own_next      = req.owner_id;
                    units_next    = req.unit_count;
                    cur_mode_next = mode_reg;
                    k_next        = '0;
                    found_next    = 1'b0;
                    vis_next      = '0;
                    frag_next     = '0;
                    if (req.req_type == REQ_ALLOC && req.unit_count == '0)
                    begin
                        st_next    = ST_INVALID;
                        state_next = S_FR_RD;
                    end
                    else
                    begin
                        state_next = S_SC_RD;
                    end
                end
            end
            S_SC_RD:
            begin
                rd_addr    = k_reg[IW-1:0];
                state_next = S_SC_EV;
            end
            S_SC_EV:
            begin
                state_next = S_SC_RD;
                k_next     = k_inc;
                if (rtype_reg == REQ_FREE)
                begin
                    if (!rd_free && rd_owner == own_reg)
                    begin
                        pick_next  = k_reg;
                        best_next  = rd_size;
                        state_next = S_NX_RD;
                    end
                    else if (last)
                    begin
                        st_next    = ST_NOT_FOUND;
                        k_next     = '0;
                        state_next = S_FR_RD;
                    end
                end
                else if (cur_mode_reg == FIT_FIRST && fits)
                begin
                    found_next  = 1'b1;
                    pick_next   = k_reg;
                    best_next   = rd_size;
                    walked_next = k_inc;
                    state_next  = S_G_DEC;
                end
                else
                begin
                    if (fits && (!found_reg || rd_size < best_reg))
                    begin
                        found_next = 1'b1;
                        pick_next  = k_reg;
                        best_next  = rd_size;
                    end
                    if (last)
                    begin
                        walked_next = count_reg;
                        if (found_reg || fits)
                        begin
                            state_next = S_G_DEC;
                        end
                        else
                        begin
                            st_next    = ST_DENIED;
                            dcnt_next  = dcnt_reg + 1'b1;
                            k_next     = '0;
                            state_next = S_FR_RD;
                        end
                    end
                end
            end
            S_G_DEC:
            begin
                st_next   = ST_ALLOCATED;
                vis_next  = walked_reg;
                gcnt_next = gcnt_reg + 1'b1;
                vsum_next = vsum_reg + CNT_W'(walked_reg);
                j_next    = count_reg;
                if (UW'(best_reg) != UW'(units_reg) && count_reg < CW'(MEM_UNITS))
                begin
                    state_next = (count_reg > pick_reg + 1'b1) ? S_SH_RD : S_G_WR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pick_reg[IW-1:0];
                    wr_data    = {1'b0, own_reg, best_reg};
                    k_next     = '0;
                    state_next = S_FR_RD;
                end
            end
            // open a slot after the chosen block
            S_SH_RD:
            begin
                rd_addr    = j_dec[IW-1:0];
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[IW-1:0];
                wr_data    = rd_data;
                j_next     = j_dec;
                state_next = (j_dec > pick_reg + 1'b1) ? S_SH_RD : S_G_WR;
            end
            S_G_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = IW'(pick_reg + 1'b1);
                wr_data    = {1'b1, {OWNER_W{1'b0}}, best_reg - SW'(units_reg)};
                count_next = count_reg + 1'b1;
                state_next = S_G_WR2;
            end
            S_G_WR2:
            begin
                wr_en      = 1'b1;
                wr_addr    = pick_reg[IW-1:0];
                wr_data    = {1'b0, own_reg, SW'(units_reg)};
                k_next     = '0;
                state_next = S_FR_RD;
            end
            // free: merge with the next block
            S_NX_RD:
            begin
                rd_addr    = IW'(pick_reg + 1'b1);
                state_next = (pick_reg + 1'b1 < count_reg) ? S_NX_EV : S_F_WK;
            end
            S_NX_EV:
            begin
                state_next = S_F_WK;
                if (rd_free)
                begin
                    best_next   = best_reg + rd_size;
                    j_next      = pick_reg + 1'b1;
                    rm_ret_next = 1'b0;
                    state_next  = S_RM_CK;
                end
            end
            S_F_WK:
            begin
                wr_en      = 1'b1;
                wr_addr    = pick_reg[IW-1:0];
                wr_data    = {1'b1, own_reg, best_reg};
                st_next    = ST_FREED;
                k_next     = '0;
                state_next = (pick_reg != '0) ? S_PV_RD : S_FR_RD;
            end
            // free: merge with the previous block
            S_PV_RD:
            begin
                rd_addr    = IW'(pick_reg - 1'b1);
                state_next = S_PV_EV;
            end
            S_PV_EV:
            begin
                state_next = S_FR_RD;
                if (rd_free)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = IW'(pick_reg - 1'b1);
                    wr_data     = {1'b1, rd_owner, rd_size + best_reg};
                    j_next      = pick_reg;
                    rm_ret_next = 1'b1;
                    state_next  = S_RM_CK;
                end
            end
            // remove entry j by shifting the tail down
            S_RM_CK:
            begin
                if (j_reg + 1'b1 < count_reg)
                begin
                    state_next = S_RM_RD;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = rm_ret_reg ? S_FR_RD : S_F_WK;
                end
            end
            S_RM_RD:
            begin
                rd_addr    = IW'(j_reg + 1'b1);
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[IW-1:0];
                wr_data    = rd_data;
                j_next     = j_reg + 1'b1;
                state_next = S_RM_CK;
            end
            // recount small free fragments
            S_FR_RD:
            begin
                rd_addr    = k_reg[IW-1:0];
                state_next = S_FR_EV;
            end
            S_FR_EV:
            begin
                if (rd_free && (rd_size == SW'(1) || rd_size == SW'(2)))
                begin
                    frag_next = frag_reg + 1'b1;
                end
                k_next     = k_inc;
                state_next = last ? S_DONE : S_FR_RD;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        ov_next     = ov_reg;
        o_st_next   = o_st_reg;
        o_vis_next  = o_vis_reg;
        o_frag_next = o_frag_reg;
        o_g_next    = o_g_reg;
        o_d_next    = o_d_reg;
        o_v_next    = o_v_reg;
        if (rsp.ready)
        begin
            ov_next = 1'b0;
        end
        if (load_out)
        begin
            ov_next     = 1'b1;
            o_st_next   = st_reg;
            o_vis_next  = VISIT_W'(vis_reg);
            o_frag_next = FRAG_W'(frag_reg);
            o_g_next    = gcnt_reg;
            o_d_next    = dcnt_reg;
            o_v_next    = vsum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= FIT_FIRST;
            count_reg <= CW'(1);
            gcnt_reg  <= '0;
            dcnt_reg  <= '0;
            vsum_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            gcnt_reg  <= gcnt_next;
            dcnt_reg  <= dcnt_next;
            vsum_reg  <= vsum_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_mode_reg <= cur_mode_next;
        rtype_reg    <= rtype_next;
        own_reg      <= own_next;
        units_reg    <= units_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        pick_reg     <= pick_next;
        walked_reg   <= walked_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        rm_ret_reg   <= rm_ret_next;
        frag_reg     <= frag_next;
        st_reg       <= st_next;
        vis_reg      <= vis_next;
        o_st_reg     <= o_st_next;
        o_vis_reg    <= o_vis_next;
        o_frag_reg   <= o_frag_next;
        o_g_reg      <= o_g_next;
        o_d_reg      <= o_d_next;
        o_v_reg      <= o_v_next;
    end

    assign rsp.valid           = ov_reg;
    assign rsp.status          = o_st_reg;
    assign rsp.nodes_visited   = o_vis_reg;
    assign rsp.small_fragments = o_frag_reg;
    assign rsp.granted_total   = o_g_reg;
    assign rsp.denied_total    = o_d_reg;
    assign rsp.visited_total   = o_v_reg;

    // checks
    `CBA_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg == '0 || count_reg > CW'(MEM_UNITS))
    `CBA_ASSERT_NEXT(a_done_to_idle, clk, rst_n, load_out, state_reg == S_IDLE && ov_reg)
    `CBA_ASSERT_IMPLY(a_visit_zero, clk, rst_n, rsp.valid && rsp.status != ST_ALLOCATED, rsp.nodes_visited == '0)
endmodule
`default_nettype wire

>>> design/cba_table.sv
// ----------------------------------------------------------------------------
// cba_table
// Block table memory: one write and one registered read per cycle.
// Entry 0 reads as one free block of the whole memory until first written.
// ----------------------------------------------------------------------------
`default_nettype none
module cba_table #(
    parameter int MEM_UNITS = cba_pkg::MEM_UNITS_DEF,
    parameter int IW        = $clog2(MEM_UNITS),
    parameter int EW        = 1 + cba_pkg::OWNER_W + $clog2(MEM_UNITS + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [EW-1:0] wr_data,
    input  wire logic [IW-1:0] rd_addr,
    output logic [EW-1:0]      rd_data
);
    import cba_pkg::*;

    localparam int SW = EW - 1 - OWNER_W;
    localparam logic [EW-1:0] INIT_ENTRY = {1'b1, {OWNER_W{1'b0}}, SW'(MEM_UNITS)};

    logic [EW-1:0] mem [MEM_UNITS];
    logic [EW-1:0] mem_q_reg;
    logic          zero_rd_reg;
    logic          e0_vld_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // entry 0 reset tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_vld_reg  <= 1'b0;
            zero_rd_reg <= 1'b0;
        end
        else
        begin
            zero_rd_reg <= (rd_addr == '0) && !e0_vld_reg;
            if (wr_en && wr_addr == '0)
            begin
                e0_vld_reg <= 1'b1;
            end
        end
    end

    assign rd_data = zero_rd_reg ? INIT_ENTRY : mem_q_reg;
endmodule
`default_nettype wire

>>> sim/cba_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_scoreboard
// Watches the configuration, request and response channels of the allocator.
// Keeps its own block table, predicts every response and compares the
// responses field by field, in order.
// ----------------------------------------------------------------------------
module cba_scoreboard (
    input  logic clk,
    input  logic rst_n,
    cba_cfg_if   cfg_mon,
    cba_req_if   req_mon,
    cba_rsp_if   rsp_mon,
    output int   fail_count,
    output int   pending
);
    import cba_pkg::*;

    localparam int UNITS = MEM_UNITS_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VISIT_W-1:0]  nodes_visited;
        logic [FRAG_W-1:0]   small_fragments;
        logic [CNT_W-1:0]    granted_total;
        logic [CNT_W-1:0]    denied_total;
        logic [CNT_W-1:0]    visited_total;
    } alloc_result_t;

    // shadow block table
    int unsigned       blk_size  [UNITS];
    logic [OWNER_W-1:0] blk_owner [UNITS];
    bit                blk_free  [UNITS];
    int unsigned       blk_count;
    logic [CNT_W-1:0]  granted_cnt, denied_cnt, visited_acc;
    logic              mode;

    alloc_result_t     result_q[$];

    assign pending = result_q.size();

    function automatic void drop_block(int unsigned idx);
        for (int unsigned k = idx; k + 1 < blk_count; k++)
        begin
            blk_size[k]  = blk_size[k+1];
            blk_owner[k] = blk_owner[k+1];
            blk_free[k]  = blk_free[k+1];
        end
        blk_count--;
    endfunction

    function automatic void take_block(int unsigned idx, logic [OWNER_W-1:0] who,
                                       int unsigned units);
        if (blk_size[idx] != units && blk_count < UNITS)
        begin
            for (int unsigned k = blk_count; k > idx + 1; k--)
            begin
                blk_size[k]  = blk_size[k-1];
                blk_owner[k] = blk_owner[k-1];
                blk_free[k]  = blk_free[k-1];
            end
            blk_size[idx+1]  = blk_size[idx] - units;
            blk_owner[idx+1] = '0;
            blk_free[idx+1]  = 1'b1;
            blk_count++;
            blk_size[idx] = units;
        end
        blk_owner[idx] = who;
        blk_free[idx]  = 1'b0;
    endfunction

    // apply one request to the shadow table, return the response it earns
    function automatic alloc_result_t serve_request(logic kind, logic [OWNER_W-1:0] who,
                                                    logic [UNITS_W-1:0] units);
        alloc_result_t r;
        int unsigned   walked, pick, best, frags;
        bit            found;
        walked = 0; pick = 0; best = 0; frags = 0; found = 0;
        r = '0;
        if (kind == REQ_ALLOC)
        begin
            if (units == 0)
                r.status = ST_INVALID;
            else
            begin
                for (int unsigned k = 0; k < blk_count; k++)
                begin
                    walked++;
                    if (blk_free[k] && blk_size[k] >= units)
                    begin
                        if (mode == FIT_FIRST)
                        begin
                            found = 1; pick = k;
                            break;
                        end
                        if (!found || blk_size[k] < best)
                        begin
                            found = 1; pick = k; best = blk_size[k];
                        end
                    end
                end
                if (found)
                begin
                    take_block(pick, who, units);
                    r.status        = ST_ALLOCATED;
                    r.nodes_visited = walked[VISIT_W-1:0];
                    granted_cnt++;
                    visited_acc += walked;
                end
                else
                begin
                    r.status = ST_DENIED;
                    denied_cnt++;
                end
            end
        end
        else
        begin
            r.status = ST_NOT_FOUND;
            for (int unsigned k = 0; k < blk_count; k++)
            begin
                if (!blk_free[k] && blk_owner[k] == who)
                begin
                    blk_free[k] = 1'b1;
                    if (k + 1 < blk_count && blk_free[k+1])
                    begin
                        blk_size[k] += blk_size[k+1];
                        drop_block(k + 1);
                    end
                    if (k > 0 && blk_free[k-1])
                    begin
                        blk_size[k-1] += blk_size[k];
                        drop_block(k);
                    end
                    r.status = ST_FREED;
                    break;
                end
            end
        end
        for (int unsigned k = 0; k < blk_count; k++)
            if (blk_free[k] && (blk_size[k] == 1 || blk_size[k] == 2))
                frags++;
        r.small_fragments = frags[FRAG_W-1:0];
        r.granted_total   = granted_cnt;
        r.denied_total    = denied_cnt;
        r.visited_total   = visited_acc;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < UNITS; k++)
            begin
                blk_size[k]  = 0;
                blk_owner[k] = '0;
                blk_free[k]  = 1'b0;
            end
            blk_size[0] = UNITS;
            blk_free[0] = 1'b1;
            blk_count   = 1;
            granted_cnt = '0;
            denied_cnt  = '0;
            visited_acc = '0;
            mode        = FIT_FIRST;
            fail_count  = 0;
            result_q.delete();
        end
        else
        begin
            // response beat against the oldest prediction
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("response beat with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (rsp_mon.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                        fail_count++;
                    end
                    if (rsp_mon.nodes_visited !== want.nodes_visited)
                    begin
                        $error("nodes_visited: expected %0d, got %0d",
                               want.nodes_visited, rsp_mon.nodes_visited);
                        fail_count++;
                    end
                    if (rsp_mon.small_fragments !== want.small_fragments)
                    begin
                        $error("small_fragments: expected %0d, got %0d",
                               want.small_fragments, rsp_mon.small_fragments);
                        fail_count++;
                    end
                    if (rsp_mon.granted_total !== want.granted_total)
                    begin
                        $error("granted_total: expected %0d, got %0d",
                               want.granted_total, rsp_mon.granted_total);
                        fail_count++;
                    end
                    if (rsp_mon.denied_total !== want.denied_total)
                    begin
                        $error("denied_total: expected %0d, got %0d",
                               want.denied_total, rsp_mon.denied_total);
                        fail_count++;
                    end
                    if (rsp_mon.visited_total !== want.visited_total)
                    begin
                        $error("visited_total: expected %0d, got %0d",
                               want.visited_total, rsp_mon.visited_total);
                        fail_count++;
                    end
                end
            end
            // mode write
            if (cfg_mon.valid && cfg_mon.ready)
                mode = cfg_mon.fit_mode;
            // request beat
            if (req_mon.valid && req_mon.ready)
                result_q.push_back(serve_request(req_mon.req_type, req_mon.owner_id,
                                                 req_mon.unit_count));
        end
    end
endmodule

>>> sim/tb_contiguous_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator
// Drives directed and random allocate/free requests in both placement modes,
// with random stalls on both channels; the scoreboard checks every response.
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator;
    import cba_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int HOLD_CYCLES = 3000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt;
    bit   quiet;
    bit   hold_rsp;

    cba_cfg_if cfg_ch();
    cba_req_if req_ch();
    cba_rsp_if rsp_ch();

    contiguous_block_allocator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cba_scoreboard u_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_mon    (cfg_ch),
        .req_mon    (req_ch),
        .rsp_mon    (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run-away guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("** contiguous_block_allocator: FAILED **");
            $finish;
        end
    end

    // response side: random stall bursts, one long hold on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // one request beat, with an optional idle burst ahead of it
    task automatic send_req(logic kind, logic [OWNER_W-1:0] who, logic [UNITS_W-1:0] units);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.owner_id   <= who;
        req_ch.unit_count <= units;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // stop sending and wait until every response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_mode(logic m);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.fit_mode <= m;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_mix(int n);
        logic [OWNER_W-1:0] who;
        logic [UNITS_W-1:0] units;
        int                 pick;
        for (int i = 0; i < n; i++)
        begin
            who = ($urandom_range(0, 9) == 0) ? OWNER_W'($urandom) :
                                                OWNER_W'($urandom_range(0, 15));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                units = '0;
            else if (pick == 1)
                units = UNITS_W'($urandom_range(200, 511));
            else if (pick < 5)
                units = UNITS_W'($urandom_range(1, 3));
            else
                units = UNITS_W'($urandom_range(1, 40));
            send_req($urandom_range(0, 1) ? REQ_FREE : REQ_ALLOC, who, units);
        end
    endtask

    // stimulus
    initial
    begin
        rst_n            = 1'b0;
        cycle_cnt        = 0;
        quiet            = 1'b0;
        hold_rsp         = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_ALLOC;
        req_ch.owner_id  = '0;
        req_ch.unit_count = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.fit_mode  = FIT_FIRST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first fit
        set_mode(FIT_FIRST);
        send_req(REQ_ALLOC, 8'd1, 9'd0);      // zero size
        send_req(REQ_ALLOC, 8'd1, 9'd257);    // oversized
        send_req(REQ_ALLOC, 8'd1, 9'd511);
        send_req(REQ_FREE,  8'd9, 9'd0);      // owner holds nothing
        send_req(REQ_ALLOC, 8'd0, 9'd256);    // exact fit, whole memory
        send_req(REQ_ALLOC, 8'd2, 9'd1);      // no room left
        send_req(REQ_FREE,  8'd0, 9'h1FF);
        send_req(REQ_ALLOC, 8'd255, 9'd1);
        send_req(REQ_ALLOC, 8'd3, 9'd2);
        send_req(REQ_ALLOC, 8'd255, 9'd10);   // same owner twice
        send_req(REQ_ALLOC, 8'd4, 9'd2);
        send_req(REQ_FREE,  8'd255, 9'd0);    // frees the lower one only
        send_req(REQ_FREE,  8'd4, 9'd0);      // merges with the next free block
        send_req(REQ_FREE,  8'd3, 9'd0);
        drain();

        // directed: best fit
        set_mode(FIT_BEST);
        send_req(REQ_ALLOC, 8'd5, 9'd5);
        send_req(REQ_ALLOC, 8'd6, 9'd40);
        send_req(REQ_FREE,  8'd255, 9'd0);
        send_req(REQ_ALLOC, 8'd7, 9'd3);      // goes to the smallest hole
        send_req(REQ_ALLOC, 8'd8, 9'd256);
        send_req(REQ_ALLOC, 8'd8, 9'd0);
        drain();

        // random, first fit; long response hold while requests keep coming
        set_mode(FIT_FIRST);
        hold_rsp = 1'b1;
        random_mix(200);
        drain();

        // full table: single-unit blocks everywhere, then release some at random
        set_mode(FIT_BEST);
        for (int i = 0; i < 8; i++) send_req(REQ_FREE, OWNER_W'(i), 9'd0);
        for (int i = 0; i < 16; i++) send_req(REQ_FREE, OWNER_W'(i), 9'd0);
        for (int i = 0; i < 260; i++) send_req(REQ_ALLOC, OWNER_W'(i), 9'd1);
        for (int i = 0; i < 40; i++)
            send_req(REQ_FREE, OWNER_W'($urandom_range(0, 255)), 9'd0);
        drain();

        // random, best fit
        random_mix(250);
        drain();

        // random, first fit, no idling
        set_mode(FIT_FIRST);
        quiet = 1'b1;
        random_mix(250);
        drain();

        if (fail_count == 0)
            $display("** contiguous_block_allocator: PASSED **");
        else
            $display("** contiguous_block_allocator: FAILED **");
        $finish;
    end
endmodule
